// File: hdl/decimal_power_of_two_minus_one_assert.svh
// assertion macros used by the datapath
`ifndef DECIMAL_POWER_OF_TWO_MINUS_ONE_ASSERT_SVH
`define DECIMAL_POWER_OF_TWO_MINUS_ONE_ASSERT_SVH
`ifndef SYNTHESIS
`define DP2M_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dp2m assertion failed");
`define DP2M_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dp2m assertion failed");
`else
`define DP2M_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DP2M_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/dp2m_pkg.sv
`default_nettype none

package dp2m_pkg;

    localparam int DG_BITS    = 40;
    localparam int IDX_BITS   = 6;
    localparam int COUNT_BITS = 21;

    // log10(2) in q0.40, split into two 20 bit halves
    localparam logic [39:0] LOG10_2_Q40 = 40'd330985980542;
    localparam logic [19:0] LOG10_2_HI  = LOG10_2_Q40[39:20];
    localparam logic [19:0] LOG10_2_LO  = LOG10_2_Q40[19:0];

    // x / 10 = (x * RECIP_10) >> RECIP_SHIFT, exact for x below 2^18
    localparam logic [17:0] RECIP_10    = 18'd209716;
    localparam int          RECIP_SHIFT = 21;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_IDLE,
        OP_INIT,
        OP_MODE,
        OP_CLR,
        OP_ROWRD,
        OP_ROWLAT,
        OP_MACRD,
        OP_MACWR,
        OP_ROWNX,
        OP_NRD,
        OP_NADD,
        OP_NWR,
        OP_TOSQR,
        OP_SHIFT,
        OP_DEC,
        OP_DECWR,
        OP_GRD,
        OP_GSH,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_LAST,
        C_E_ZERO,
        C_A_ZERO,
        C_NOT_ROWEND,
        C_MODE_SQR,
        C_NOT_GROUP_END,
        C_OUT_BUSY,
        C_NOT_LAST_G
    } t_cond;

    typedef logic [4:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic no_input;
        logic not_last;
        logic e_zero;
        logic a_zero;
        logic not_rowend;
        logic mode_sqr;
        logic not_group_end;
        logic out_busy;
        logic not_last_g;
    } t_status;

    localparam t_pc P_IDLE   = 5'd0;
    localparam t_pc P_INIT   = 5'd1;
    localparam t_pc P_TEST   = 5'd2;
    localparam t_pc P_MODE   = 5'd3;
    localparam t_pc P_CLR    = 5'd4;
    localparam t_pc P_ROWRD  = 5'd5;
    localparam t_pc P_ROWLAT = 5'd6;
    localparam t_pc P_MACRD  = 5'd7;
    localparam t_pc P_MACWR  = 5'd8;
    localparam t_pc P_ROWNX  = 5'd9;
    localparam t_pc P_NRD    = 5'd10;
    localparam t_pc P_NADD   = 5'd11;
    localparam t_pc P_NWR    = 5'd12;
    localparam t_pc P_RET    = 5'd13;
    localparam t_pc P_TOSQR  = 5'd14;
    localparam t_pc P_SHIFT  = 5'd15;
    localparam t_pc P_DEC    = 5'd16;
    localparam t_pc P_DECWR  = 5'd17;
    localparam t_pc P_GRD    = 5'd18;
    localparam t_pc P_GSH    = 5'd19;
    localparam t_pc P_WAITO  = 5'd20;
    localparam t_pc P_EMIT   = 5'd21;
    localparam t_pc P_DONE   = 5'd22;

    // control store: jump to target when cond holds, else step on
    function automatic t_uword prog_word(input t_pc pc);
        t_uword w;
        unique case (pc)
            P_IDLE:   w = '{OP_IDLE,   C_NO_INPUT,      P_IDLE};
            P_INIT:   w = '{OP_INIT,   C_NOT_LAST,      P_INIT};
            P_TEST:   w = '{OP_NOP,    C_E_ZERO,        P_DEC};
            P_MODE:   w = '{OP_MODE,   C_NEVER,         P_IDLE};
            P_CLR:    w = '{OP_CLR,    C_NOT_LAST,      P_CLR};
            P_ROWRD:  w = '{OP_ROWRD,  C_NEVER,         P_IDLE};
            P_ROWLAT: w = '{OP_ROWLAT, C_A_ZERO,        P_ROWNX};
            P_MACRD:  w = '{OP_MACRD,  C_NEVER,         P_IDLE};
            P_MACWR:  w = '{OP_MACWR,  C_NOT_ROWEND,    P_MACRD};
            P_ROWNX:  w = '{OP_ROWNX,  C_NOT_LAST,      P_ROWRD};
            P_NRD:    w = '{OP_NRD,    C_NEVER,         P_IDLE};
            P_NADD:   w = '{OP_NADD,   C_NEVER,         P_IDLE};
            P_NWR:    w = '{OP_NWR,    C_NOT_LAST,      P_NRD};
            P_RET:    w = '{OP_NOP,    C_MODE_SQR,      P_SHIFT};
            P_TOSQR:  w = '{OP_TOSQR,  C_ALWAYS,        P_CLR};
            P_SHIFT:  w = '{OP_SHIFT,  C_ALWAYS,        P_TEST};
            P_DEC:    w = '{OP_DEC,    C_NEVER,         P_IDLE};
            P_DECWR:  w = '{OP_DECWR,  C_NEVER,         P_IDLE};
            P_GRD:    w = '{OP_GRD,    C_NEVER,         P_IDLE};
            P_GSH:    w = '{OP_GSH,    C_NOT_GROUP_END, P_GRD};
            P_WAITO:  w = '{OP_NOP,    C_OUT_BUSY,      P_WAITO};
            P_EMIT:   w = '{OP_EMIT,   C_NOT_LAST_G,    P_GRD};
            default:  w = '{OP_NOP,    C_ALWAYS,        P_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/dp2m_ram.sv
`default_nettype none

module dp2m_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 500
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/dp2m_seq.sv
`default_nettype none

module dp2m_seq
    import dp2m_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_op          o_op
);

    t_pc    r_pc;
    t_uword w_word;
    logic   w_jump;

    always_comb begin
        w_word = prog_word(r_pc);
        unique case (w_word.cond)
            C_NEVER:         w_jump = 1'b0;
            C_ALWAYS:        w_jump = 1'b1;
            C_NO_INPUT:      w_jump = i_status.no_input;
            C_NOT_LAST:      w_jump = i_status.not_last;
            C_E_ZERO:        w_jump = i_status.e_zero;
            C_A_ZERO:        w_jump = i_status.a_zero;
            C_NOT_ROWEND:    w_jump = i_status.not_rowend;
            C_MODE_SQR:      w_jump = i_status.mode_sqr;
            C_NOT_GROUP_END: w_jump = i_status.not_group_end;
            C_OUT_BUSY:      w_jump = i_status.out_busy;
            C_NOT_LAST_G:    w_jump = i_status.not_last_g;
            default:         w_jump = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= P_IDLE;
        end else begin
            r_pc <= w_jump ? w_word.target : r_pc + 1'b1;
        end
    end

    assign o_op = w_word.op;

endmodule

`default_nettype wire

// File: hdl/dp2m_dp.sv
`default_nettype none
`include "decimal_power_of_two_minus_one_assert.svh"

module dp2m_dp
    import dp2m_pkg::*;
#(
    parameter int DIGITS        = 500,
    parameter int GROUP_DIGITS  = 10,
    parameter int EXPONENT_BITS = 22
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_op                      i_op,
    output t_status                       o_status,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [EXPONENT_BITS-1:0] i_exponent,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [DG_BITS-1:0]            o_digit_group,
    output logic [IDX_BITS-1:0]           o_group_index,
    output logic [COUNT_BITS-1:0]         o_digit_count,
    output logic                          o_last_group
);

    localparam int GROUPS   = (DIGITS + GROUP_DIGITS - 1) / GROUP_DIGITS;
    localparam int POS_SPAN = GROUPS * GROUP_DIGITS;
    localparam int IB       = $clog2(DIGITS);
    localparam int SB       = $clog2(DIGITS * 90 + 1);
    localparam int PB       = $clog2(POS_SPAN + 1);
    localparam int GB       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int KB       = (GROUP_DIGITS > 1) ? $clog2(GROUP_DIGITS) : 1;
    localparam int GW       = 4 * GROUP_DIGITS;
    localparam int EB       = EXPONENT_BITS;
    localparam int QW       = SB + 18;

    typedef enum logic {
        MODE_MUL,
        MODE_SQR
    } t_mode;

    t_mode                 r_mode;
    logic [IB-1:0]         r_i;
    logic [IB-1:0]         r_j;
    logic [EB-1:0]         r_e;
    logic [EB-1:0]         r_p;
    logic [3:0]            r_a;
    logic [SB-1:0]         r_v;
    logic [SB-1:0]         r_carry;
    logic [PB-1:0]         r_pos;
    logic [KB-1:0]         r_k;
    logic [GB-1:0]         r_g;
    logic [GW-1:0]         r_shift;
    logic [EB+19:0]        r_pl;
    logic [EB+19:0]        r_ph;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_o_valid;
    logic [DG_BITS-1:0]    r_o_digit_group;
    logic [IDX_BITS-1:0]   r_o_group_index;
    logic [COUNT_BITS-1:0] r_o_digit_count;
    logic                  r_o_last_group;

    logic                  res_we;
    logic [3:0]            res_wdata;
    logic [IB-1:0]         res_raddr;
    logic [3:0]            res_rd;
    logic                  base_we;
    logic [3:0]            base_wdata;
    logic [IB-1:0]         base_raddr;
    logic [3:0]            base_rd;
    logic                  cs_we;
    logic [IB-1:0]         cs_waddr;
    logic [SB-1:0]         cs_wdata;
    logic [IB-1:0]         cs_raddr;
    logic [SB-1:0]         cs_rd;

    logic [IB:0]           w_ij;
    logic [3:0]            w_a_rd;
    logic                  w_i_last;
    logic                  w_g_last;
    logic                  w_k_last;
    logic                  w_pos_valid;
    logic [3:0]            w_digit;
    logic [7:0]            w_mac;
    logic [QW-1:0]         w_qp;
    logic [SB-1:0]         w_q;
    logic [SB-1:0]         w_q10;
    logic [SB-1:0]         w_rem;
    logic [EB+20:0]        w_t;
    logic [EB+20:0]        w_cnt;

    dp2m_ram #(.WIDTH(4), .DEPTH(DIGITS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (r_i),
        .i_wdata (res_wdata),
        .i_raddr (res_raddr),
        .o_rdata (res_rd)
    );

    dp2m_ram #(.WIDTH(4), .DEPTH(DIGITS)) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (base_we),
        .i_waddr (r_i),
        .i_wdata (base_wdata),
        .i_raddr (base_raddr),
        .o_rdata (base_rd)
    );

    dp2m_ram #(.WIDTH(SB), .DEPTH(DIGITS)) u_cs_ram (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (cs_waddr),
        .i_wdata (cs_wdata),
        .i_raddr (cs_raddr),
        .o_rdata (cs_rd)
    );

    assign w_ij        = {1'b0, r_i} + {1'b0, r_j};
    assign w_a_rd      = (r_mode == MODE_SQR) ? base_rd : res_rd;
    assign w_i_last    = r_i == IB'(DIGITS - 1);
    assign w_g_last    = r_g == GB'(GROUPS - 1);
    assign w_k_last    = r_k == KB'(GROUP_DIGITS - 1);
    assign w_pos_valid = r_pos < PB'(DIGITS);
    assign w_digit     = w_pos_valid ? res_rd : 4'd0;
    assign w_mac       = {4'd0, r_a} * {4'd0, base_rd};

    // carry normalisation: divide by ten through the reciprocal
    assign w_qp  = QW'(r_v) * QW'(RECIP_10);
    assign w_q   = SB'(w_qp >> RECIP_SHIFT);
    assign w_q10 = (w_q << 3) + (w_q << 1);
    assign w_rem = r_v - w_q10;

    // digit count from the two registered partial products
    assign w_t   = (EB + 21)'(r_ph) + (EB + 21)'(r_pl >> 20);
    assign w_cnt = (EB + 21)'(w_t >> 20) + (EB + 21)'(1);

    always_comb begin
        res_we  = (i_op == OP_INIT) || (i_op == OP_DECWR)
               || ((i_op == OP_NWR) && (r_mode == MODE_MUL));
        base_we = (i_op == OP_INIT) || ((i_op == OP_NWR) && (r_mode == MODE_SQR));
        if (i_op == OP_INIT) begin
            res_wdata  = (r_i == '0) ? 4'd1 : 4'd0;
            base_wdata = (r_i == '0) ? 4'd2 : 4'd0;
        end else if (i_op == OP_DECWR) begin
            res_wdata  = res_rd - 4'd1;
            base_wdata = w_rem[3:0];
        end else begin
            res_wdata  = w_rem[3:0];
            base_wdata = w_rem[3:0];
        end
        res_raddr  = (i_op == OP_GRD) ? r_pos[IB-1:0] : r_i;
        base_raddr = (i_op == OP_MACRD) ? r_j : r_i;
        cs_we      = (i_op == OP_CLR) || (i_op == OP_MACWR);
        cs_waddr   = (i_op == OP_MACWR) ? w_ij[IB-1:0] : r_i;
        cs_wdata   = (i_op == OP_MACWR) ? cs_rd + SB'(w_mac) : '0;
        cs_raddr   = (i_op == OP_MACRD) ? w_ij[IB-1:0] : r_i;
    end

    always_comb begin
        o_status.no_input      = !i_valid;
        o_status.not_last      = !w_i_last;
        o_status.e_zero        = r_e == '0;
        o_status.a_zero        = w_a_rd == 4'd0;
        o_status.not_rowend    = w_ij != (IB + 1)'(DIGITS - 1);
        o_status.mode_sqr      = r_mode == MODE_SQR;
        o_status.not_group_end = !w_k_last;
        o_status.out_busy      = r_o_valid && !i_ready;
        o_status.not_last_g    = !w_g_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_g       <= '0;
            r_e       <= '0;
            r_mode    <= MODE_MUL;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (i_op)
                OP_IDLE: begin
                    if (i_valid) begin
                        r_e <= i_exponent;
                    end
                end
                OP_INIT, OP_CLR, OP_ROWNX, OP_NWR: begin
                    r_i <= w_i_last ? '0 : r_i + 1'b1;
                end
                OP_MODE:   r_mode <= r_e[0] ? MODE_MUL : MODE_SQR;
                OP_ROWLAT: r_j <= '0;
                OP_MACWR:  r_j <= r_j + 1'b1;
                OP_TOSQR:  r_mode <= MODE_SQR;
                OP_SHIFT:  r_e <= r_e >> 1;
                OP_DEC: begin
                    r_k <= '0;
                    r_g <= '0;
                end
                OP_GSH:    r_k <= w_k_last ? '0 : r_k + 1'b1;
                OP_EMIT: begin
                    r_g       <= w_g_last ? '0 : r_g + 1'b1;
                    r_o_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl    <= (EB + 20)'(r_p) * (EB + 20)'(LOG10_2_LO);
        r_ph    <= (EB + 20)'(r_p) * (EB + 20)'(LOG10_2_HI);
        r_count <= w_cnt[COUNT_BITS-1:0];
        unique case (i_op)
            OP_IDLE: begin
                if (i_valid) begin
                    r_p <= i_exponent;
                end
            end
            OP_ROWLAT: r_a <= w_a_rd;
            OP_CLR:    r_carry <= '0;
            OP_NADD:   r_v <= cs_rd + r_carry;
            OP_NWR:    r_carry <= w_q;
            OP_DEC:    r_pos <= PB'(POS_SPAN - 1);
            OP_GSH: begin
                r_shift <= GW'({r_shift, w_digit});
                r_pos   <= r_pos - 1'b1;
            end
            OP_EMIT: begin
                r_o_digit_group <= DG_BITS'(r_shift);
                r_o_group_index <= IDX_BITS'(r_g);
                r_o_digit_count <= r_count;
                r_o_last_group  <= w_g_last;
            end
            default: ;
        endcase
    end

    assign o_ready       = i_op == OP_IDLE;
    assign o_valid       = r_o_valid;
    assign o_digit_group = r_o_digit_group;
    assign o_group_index = r_o_group_index;
    assign o_digit_count = r_o_digit_count;
    assign o_last_group  = r_o_last_group;

    `DP2M_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_op == OP_EMIT, !r_o_valid)
    `DP2M_ASSERT_IMP(a_norm_digit, i_clk, i_rst_n, i_op == OP_NWR, w_rem < SB'(10))
    `DP2M_ASSERT_IMP(a_mac_range, i_clk, i_rst_n, i_op == OP_MACWR, w_ij < (IB + 1)'(DIGITS))
    `DP2M_ASSERT_NEXT(a_last_out, i_clk, i_rst_n, (i_op == OP_EMIT) && w_g_last, o_valid && o_last_group)

endmodule

`default_nettype wire

// File: hdl/decimal_power_of_two_minus_one.sv
// last decimal digits of 2^p - 1
// input channel: i_valid / o_ready carries the exponent p; one transfer per item
// output channel: o_valid / i_ready carries ceil(DIGITS/GROUP_DIGITS) transfers per item,
//   most significant group first, each with its group number, the digit count
//   floor(p*log10 2)+1 and a flag on the least significant group
// the work is square-and-multiply on digit memories driven by a small control store;
//   one shared digit multiply-add unit does every product
// up to two products per exponent bit; an item runs through the setup of the digit
//   memories, the products and the final decrement, then the output groups one after
//   another
// o_ready is high only while the block waits for an item; the final group may still
//   sit in the output register when the next item is taken
// a stalled receiver holds the current group; the block waits until it is taken
// after reset the block is idle with no output pending

`default_nettype none

module decimal_power_of_two_minus_one
    import dp2m_pkg::*;
#(
    parameter int DIGITS        = 500,
    parameter int GROUP_DIGITS  = 10,
    parameter int EXPONENT_BITS = 22
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [EXPONENT_BITS-1:0] i_exponent,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [DG_BITS-1:0]            o_digit_group,
    output logic [IDX_BITS-1:0]           o_group_index,
    output logic [COUNT_BITS-1:0]         o_digit_count,
    output logic                          o_last_group
);

    t_op     w_op;
    t_status w_status;

    dp2m_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    dp2m_dp #(
        .DIGITS        (DIGITS),
        .GROUP_DIGITS  (GROUP_DIGITS),
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .o_status      (w_status),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_exponent    (i_exponent),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digit_group (o_digit_group),
        .o_group_index (o_group_index),
        .o_digit_count (o_digit_count),
        .o_last_group  (o_last_group)
    );

endmodule

`default_nettype wire

// File: verif/decimal_power_of_two_minus_one_test.sv
`default_nettype none

module decimal_power_of_two_minus_one_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dp2m_pkg::*;

    localparam int      N_DIGITS     = 500;
    localparam int      GROUP_DIGITS = 10;
    localparam int      N_GROUPS     = (N_DIGITS + GROUP_DIGITS - 1) / GROUP_DIGITS;
    localparam int      EXP_BITS     = 22;
    localparam longint  LOG2_Q40     = 64'd330985980542;
    localparam int      HOLD_CYCLES  = 6000;
    localparam int      CALM_ITEMS   = 10;
    localparam int      TAIL_CYCLES  = 2000;
    localparam int      RANDOM_ITEMS = 77;
    localparam longint  LIMIT_CYCLES = 200_000_000;

    typedef struct packed {
        logic [EXP_BITS-1:0] exponent;
        logic                drain;
    } t_exponent_job;

    typedef struct packed {
        logic [DG_BITS-1:0]    digits;
        logic [IDX_BITS-1:0]   index;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } t_digit_group;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    logic [EXP_BITS-1:0]   i_exponent = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    logic [DG_BITS-1:0]    o_digit_group;
    logic [IDX_BITS-1:0]   o_group_index;
    logic [COUNT_BITS-1:0] o_digit_count;
    logic                  o_last_group;

    t_exponent_job pending_exponents [$];
    t_digit_group  awaited_groups [$];

    logic [3:0]  power_digits [N_DIGITS];
    logic [3:0]  square_digits [N_DIGITS];
    int unsigned column_acc [N_DIGITS];

    int          mismatches = 0;
    int unsigned send_gap   = 0;
    int unsigned recv_gap   = 0;
    int unsigned hold_left  = HOLD_CYCLES;
    logic        calm       = 1'b0;

    decimal_power_of_two_minus_one #(
        .DIGITS        (N_DIGITS),
        .GROUP_DIGITS  (GROUP_DIGITS),
        .EXPONENT_BITS (EXP_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_exponent    (i_exponent),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_digit_group (o_digit_group),
        .o_group_index (o_group_index),
        .o_digit_count (o_digit_count),
        .o_last_group  (o_last_group)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // truncated schoolbook product; multiplies the power by the square, or squares the square
    function automatic void truncated_product(input bit into_square);
        int unsigned row_digit;
        int unsigned carry;
        for (int c = 0; c < N_DIGITS; c++)
            column_acc[c] = 0;
        for (int r = 0; r < N_DIGITS; r++) begin
            row_digit = into_square ? square_digits[r] : power_digits[r];
            if (row_digit != 0) begin
                for (int c = 0; r + c < N_DIGITS; c++)
                    column_acc[r + c] += row_digit * square_digits[c];
            end
        end
        carry = 0;
        for (int c = 0; c < N_DIGITS; c++) begin
            carry += column_acc[c];
            if (into_square)
                square_digits[c] = carry % 10;
            else
                power_digits[c] = carry % 10;
            carry = carry / 10;
        end
    endfunction

    function automatic void predict_mersenne_tail(input logic [EXP_BITS-1:0] p);
        logic [63:0]         wide_p;
        logic [63:0]         scaled;
        logic [EXP_BITS-1:0] left;
        t_digit_group        g;
        int                  pos;
        wide_p = 64'(p);
        scaled = wide_p * (LOG2_Q40 >> 20) + ((wide_p * (LOG2_Q40 & 64'hFFFFF)) >> 20);
        for (int d = 0; d < N_DIGITS; d++) begin
            power_digits[d]  = 4'd0;
            square_digits[d] = 4'd0;
        end
        power_digits[0]  = 4'd1;
        square_digits[0] = 4'd2;
        left = p;
        while (left != 0) begin
            if (left[0])
                truncated_product(1'b0);
            left = left >> 1;
            truncated_product(1'b1);
        end
        // 2^p never ends in zero, so no borrow
        power_digits[0] = power_digits[0] - 4'd1;
        for (int n = 0; n < N_GROUPS; n++) begin
            g.digits = '0;
            for (int k = 0; k < GROUP_DIGITS; k++) begin
                pos = (N_GROUPS - 1 - n) * GROUP_DIGITS + (GROUP_DIGITS - 1 - k);
                g.digits = {g.digits[DG_BITS-5:0], (pos < N_DIGITS) ? power_digits[pos] : 4'd0};
            end
            g.index = IDX_BITS'(n);
            g.count = COUNT_BITS'((scaled >> 20) + 1);
            g.last  = (n == N_GROUPS - 1);
            awaited_groups.push_back(g);
        end
    endfunction

    // long receiver hold-off straight after reset, so the block stalls with a full output
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
            calm     <= 1'b0;
        end else begin
            calm <= pending_exponents.size() <= CALM_ITEMS;
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    i_valid  <= 1'b0;
                    send_gap <= $urandom_range(1, 15);
                end else if (pending_exponents.size() != 0 &&
                             (!pending_exponents[0].drain ||
                              (!i_valid && awaited_groups.size() == 0))) begin
                    i_valid    <= 1'b1;
                    i_exponent <= pending_exponents[0].exponent;
                    pending_exponents.delete(0);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        int unsigned gap_next;
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            gap_next = recv_gap;
            if (gap_next != 0)
                gap_next = gap_next - 1;
            else if (!calm && $urandom_range(0, 7) == 0)
                gap_next = $urandom_range(1, 15);
            recv_gap <= gap_next;
            i_ready  <= (gap_next == 0) && (hold_left == 0);
        end
    end

    // output check comes first so a group never meets the expectations of the item taken alongside it
    always @(posedge i_clk) begin : monitor
        t_digit_group seen;
        t_digit_group want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                seen = '{o_digit_group, o_group_index, o_digit_count, o_last_group};
                if (awaited_groups.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: index %0d digits %h count %0d last %0b",
                                 seen.index, seen.digits, seen.count, seen.last);
                end else begin
                    want = awaited_groups[0];
                    awaited_groups.delete(0);
                    if (seen.digits !== want.digits || seen.index !== want.index ||
                        seen.count !== want.count || seen.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: expected index %0d digits %h count %0d last %0b, ",
                                   want.index, want.digits, want.count, want.last);
                            $display("got index %0d digits %h count %0d last %0b",
                                     seen.index, seen.digits, seen.count, seen.last);
                        end
                    end
                end
            end
            if (i_valid && o_ready)
                predict_mersenne_tail(i_exponent);
        end
    end

    initial begin
        t_exponent_job job;
        int unsigned   directed [];
        directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 15, 16, 31, 32,
                     33, 63, 64, 99, 100, 128, 255, 4194303};
        foreach (directed[n]) begin
            job.exponent = EXP_BITS'(directed[n]);
            job.drain    = 1'b0;
            pending_exponents.push_back(job);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 3) != 0)
                job.exponent = EXP_BITS'($urandom_range(0, 31));
            else
                job.exponent = EXP_BITS'($urandom_range(32, 255));
            // one pause until everything outstanding has been received
            job.drain = (n == 0);
            pending_exponents.push_back(job);
        end

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_exponents.size() != 0 || i_valid || awaited_groups.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && awaited_groups.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
